FILE: src/aosrts_pkg.sv
// ----------------------------------------------------------------------------
// aosrts_pkg
// Shared types, constants and helpers for the row tridiagonal solver.
// ----------------------------------------------------------------------------
package aosrts_pkg;

   localparam int ROW_LEN_DEF = 64;
   localparam int PIX_W       = 16;
   localparam int QW          = 32;

   localparam logic [PIX_W-1:0]      TS_RESET = 16'd256;
   localparam logic signed [QW-1:0]  Q_ONE    = 32'sd65536;
   localparam logic signed [QW-1:0]  Q_MAX    = 32'sh7fffffff;
   localparam logic signed [QW-1:0]  Q_MIN    = 32'sh80000000;
   localparam logic [2*QW-1:0]       MAG_LIM  = 64'h0000_0000_8000_0000;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_START,
      ST_I0,
      ST_I1,
      ST_I2,
      ST_I3,
      ST_F0,
      ST_F1,
      ST_FDIV,
      ST_F3,
      ST_F4,
      ST_F5,
      ST_BI,
      ST_BIW,
      ST_B0,
      ST_B1,
      ST_B2,
      ST_B3,
      ST_B4,
      ST_B5,
      ST_OINIT,
      ST_ORD,
      ST_OLD,
      ST_OWAIT
   } state_type;

   typedef enum logic [1:0] {
      RD_ZERO,
      RD_ONE,
      RD_FWD,
      RD_IDX
   } rd_sel_type;

   typedef enum logic [1:0] {
      MUL_LO_OFF,
      MUL_LO_F,
      MUL_OFF_X
   } mul_sel_type;

   typedef enum logic [1:0] {
      DIV_OFF_M,
      DIV_F_M,
      DIV_NUM_M
   } div_src_type;

   typedef struct packed {
      logic        store;
      rd_sel_type  rd_sel;
      logic        ld_head;
      logic        ld_g1;
      logic        init_row;
      logic        ld_off;
      logic        ld_next;
      logic        div_start;
      div_src_type div_src;
      logic        ld_diag;
      logic        ld_lo;
      mul_sel_type mul_sel;
      logic        ld_piv;
      logic        ld_fwd;
      logic        ld_back;
      logic        ld_x;
      logic        shift_back;
      logic        out_init;
      logic        ld_rsp;
      logic        out_next;
      logic        row_done;
   } cmd_type;

   typedef struct packed {
      logic single_row;
      logic fwd_last;
      logic idx_zero;
      logic out_last;
      logic div_done;
   } stat_type;

   // signed Q16.16 from a magnitude and a sign, saturated
   function automatic logic signed [QW-1:0] sat_mag(input logic neg,
                                                    input logic [2*QW-1:0] r);
      logic signed [QW-1:0] v;
      if (neg) begin
         v = (r > MAG_LIM) ? Q_MIN : -$signed(r[QW-1:0]);
      end else begin
         v = (r >= MAG_LIM) ? Q_MAX : $signed(r[QW-1:0]);
      end
      return v;
   endfunction

endpackage

FILE: src/aosrts_if.sv
// ----------------------------------------------------------------------------
// aosrts_if
// Valid/ready channel interfaces for sample input and solution output.
// ----------------------------------------------------------------------------
interface aosrts_req_if;
   import aosrts_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_value;
   logic [PIX_W-1:0] diffusivity;
   logic             row_end;

   modport source (output valid, pixel_value, diffusivity, row_end, input ready);
   modport sink   (input valid, pixel_value, diffusivity, row_end, output ready);
endinterface

interface aosrts_rsp_if;
   import aosrts_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] solved_value;
   logic             result_end;
   logic             row_overflow;

   modport source (output valid, solved_value, result_end, row_overflow, input ready);
   modport sink   (input valid, solved_value, result_end, row_overflow, output ready);
endinterface

FILE: src/aosrts_ram.sv
// ----------------------------------------------------------------------------
// aosrts_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module aosrts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: src/aosrts_div.sv
// ----------------------------------------------------------------------------
// aosrts_div
// Bit-serial rounded Q16.16 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aosrts_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [aosrts_pkg::QW-1:0]   num,
   input  logic signed [aosrts_pkg::QW-1:0]   den,
   output logic                               done,
   output logic signed [aosrts_pkg::QW-1:0]   quot
);
   import aosrts_pkg::*;

   localparam int DW = QW + 16;
   localparam int NW = $clog2(DW);

   logic          busy_ff;
   logic          done_ff;
   logic [NW-1:0] cnt_ff;
   logic [QW-1:0] rem_ff;
   logic [DW-1:0] quo_ff;
   logic [QW-1:0] den_ff;
   logic          neg_ff;

   logic [QW:0]   trial;
   logic          fits;
   logic [QW-1:0] num_mag;

   assign num_mag = num[QW-1] ? $unsigned(-num) : $unsigned(num);
   assign trial   = {rem_ff, quo_ff[DW-1]};
   assign fits    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= NW'(DW - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - NW'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= {num_mag, 16'h0000} + DW'($unsigned(den) >> 1);
         rem_ff <= '0;
         den_ff <= $unsigned(den);
         neg_ff <= num[QW-1];
      end else if (busy_ff) begin
         rem_ff <= fits ? QW'(trial - {1'b0, den_ff}) : trial[QW-1:0];
         quo_ff <= {quo_ff[DW-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quot = sat_mag(neg_ff, (2*QW)'(quo_ff));

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
endmodule

FILE: src/aosrts_ctrl.sv
// ----------------------------------------------------------------------------
// aosrts_ctrl
// Sequencer: row collection, forward elimination, back substitution, output.
// ----------------------------------------------------------------------------
module aosrts_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_row_end,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  aosrts_pkg::stat_type  stat,
   output aosrts_pkg::cmd_type   cmd
);
   import aosrts_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid && req_row_end) state_in = ST_START;
         ST_START: state_in = stat.single_row ? ST_OINIT : ST_I0;
         ST_I0:    state_in = ST_I1;
         ST_I1:    state_in = ST_I2;
         ST_I2:    state_in = ST_I3;
         ST_I3:    state_in = ST_F0;
         ST_F0:    state_in = ST_F1;
         ST_F1:    state_in = ST_FDIV;
         ST_FDIV:  if (stat.div_done) state_in = ST_F3;
         ST_F3:    state_in = ST_F4;
         ST_F4:    state_in = ST_F5;
         ST_F5:    state_in = stat.fwd_last ? ST_BI : ST_F0;
         ST_BI:    state_in = ST_BIW;
         ST_BIW:   if (stat.div_done) state_in = ST_B0;
         ST_B0:    state_in = ST_B1;
         ST_B1:    state_in = ST_B2;
         ST_B2:    state_in = ST_B3;
         ST_B3:    state_in = ST_B4;
         ST_B4:    state_in = ST_B5;
         ST_B5: begin
            if (stat.div_done) state_in = stat.idx_zero ? ST_OINIT : ST_B0;
         end
         ST_OINIT: state_in = ST_ORD;
         ST_ORD:   state_in = ST_OLD;
         ST_OLD:   state_in = ST_OWAIT;
         ST_OWAIT: begin
            if (rsp_ready) state_in = stat.out_last ? ST_IDLE : ST_ORD;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.store = req_valid;
         end
         ST_I0: cmd.rd_sel = RD_ZERO;
         ST_I1: begin
            cmd.rd_sel  = RD_ONE;
            cmd.ld_head = 1'b1;
         end
         ST_I2: cmd.ld_g1    = 1'b1;
         ST_I3: cmd.init_row = 1'b1;
         ST_F0: begin
            cmd.rd_sel = RD_FWD;
            cmd.ld_off = 1'b1;
         end
         ST_F1: begin
            cmd.ld_next   = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_OFF_M;
         end
         ST_FDIV: begin
            cmd.ld_diag = 1'b1;
            cmd.ld_lo   = stat.div_done;
         end
         ST_F3: cmd.mul_sel = MUL_LO_OFF;
         ST_F4: begin
            cmd.ld_piv  = 1'b1;
            cmd.mul_sel = MUL_LO_F;
         end
         ST_F5: cmd.ld_fwd = 1'b1;
         ST_BI: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_F_M;
         end
         ST_BIW: cmd.ld_x = stat.div_done;
         ST_B0:  cmd.rd_sel  = RD_IDX;
         ST_B1:  cmd.ld_back = 1'b1;
         ST_B2:  cmd.ld_off  = 1'b1;
         ST_B3:  cmd.mul_sel = MUL_OFF_X;
         ST_B4: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_NUM_M;
         end
         ST_B5: begin
            cmd.ld_x       = stat.div_done;
            cmd.shift_back = stat.div_done;
         end
         ST_OINIT: cmd.out_init = 1'b1;
         ST_ORD:   cmd.rd_sel   = RD_IDX;
         ST_OLD:   cmd.ld_rsp   = 1'b1;
         ST_OWAIT: begin
            rsp_valid    = 1'b1;
            cmd.out_next = rsp_ready && !stat.out_last;
            cmd.row_done = rsp_ready && stat.out_last;
         end
         default: cmd = '0;
      endcase
   end
endmodule

FILE: src/aosrts_dp.sv
// ----------------------------------------------------------------------------
// aosrts_dp
// Datapath: row stores, coefficient arithmetic, shared multiplier and divider.
// ----------------------------------------------------------------------------
module aosrts_dp #(
   parameter int ROW_LEN = aosrts_pkg::ROW_LEN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  aosrts_pkg::cmd_type             cmd,
   output aosrts_pkg::stat_type            stat,
   input  logic [aosrts_pkg::PIX_W-1:0]    req_pixel_value,
   input  logic [aosrts_pkg::PIX_W-1:0]    req_diffusivity,
   input  logic                            csr_wr_en,
   input  logic [aosrts_pkg::PIX_W-1:0]    csr_wr_data,
   output logic [aosrts_pkg::PIX_W-1:0]    rsp_solved_value,
   output logic                            rsp_result_end,
   output logic                            rsp_row_overflow
);
   import aosrts_pkg::*;

   localparam int AW = $clog2(ROW_LEN);
   localparam int CW = $clog2(ROW_LEN + 1);
   localparam int SW = PIX_W + 2;
   localparam int PW = PIX_W + SW;
   localparam int MW = 2 * QW;

   function automatic logic signed [QW-1:0] scale_sum(input logic [PIX_W-1:0] ts,
                                                      input logic [SW-1:0] s);
      logic [PW-1:0] p;
      p = PW'(ts) * PW'(s);
      return $signed(QW'((p + PW'(128)) >> 8));
   endfunction

   function automatic logic signed [QW-1:0] sat_sub(input logic signed [QW-1:0] a,
                                                    input logic signed [QW-1:0] b);
      logic signed [QW:0] d;
      d = {a[QW-1], a} - {b[QW-1], b};
      if (d[QW] != d[QW-1]) begin
         return d[QW] ? Q_MIN : Q_MAX;
      end
      return d[QW-1:0];
   endfunction

   function automatic logic [QW-1:0] mag(input logic signed [QW-1:0] v);
      return v[QW-1] ? $unsigned(-v) : $unsigned(v);
   endfunction

   function automatic logic [PIX_W-1:0] sat_pix(input logic signed [QW-1:0] v);
      if (v[QW-1]) return '0;
      if (v > $signed(QW'(65535))) return {PIX_W{1'b1}};
      return v[PIX_W-1:0];
   endfunction

   logic [PIX_W-1:0]       ts_ff;
   logic [CW-1:0]          fill_ff;
   logic                   ovf_ff;
   logic [AW-1:0]          idx_ff;
   logic [PIX_W-1:0]       g0_ff, g1_ff, g2_ff, smp_ff;
   logic signed [QW-1:0]   m_ff, f_ff, off_ff, lo_ff, x_ff, diag_ff;
   logic [MW-1:0]          pm_ff;
   logic                   pneg_ff;
   logic [PIX_W-1:0]       rsp_value_ff;
   logic                   rsp_end_ff, rsp_ovf_ff;

   logic                   room, interior;
   logic [AW-1:0]          idx_p1, idx_p2;
   logic [SW-1:0]          sum_pair, sum_diag;
   logic signed [QW-1:0]   sc_pair, sc_diag, smp32, qm;
   logic signed [QW-1:0]   m_init, m_in, f_in, num_in, mul_a, mul_b, div_num, div_q;
   logic                   div_done;

   logic                   smp_we, cond_we, piv_we, fwd_we;
   logic [AW-1:0]          smp_wa, piv_wa, smp_ra, cond_ra;
   logic [PIX_W-1:0]       smp_wd, smp_q, cond_q;
   logic [QW-1:0]          piv_wd, fwd_wd, piv_q, fwd_q;

   assign room     = fill_ff < CW'(ROW_LEN);
   assign idx_p1   = idx_ff + AW'(1);
   assign idx_p2   = idx_ff + AW'(2);
   assign interior = (CW'(idx_ff) + CW'(2)) < fill_ff;

   assign stat.single_row = fill_ff == CW'(1);
   assign stat.fwd_last   = (CW'(idx_ff) + CW'(2)) == fill_ff;
   assign stat.idx_zero   = idx_ff == '0;
   assign stat.out_last   = (CW'(idx_ff) + CW'(1)) == fill_ff;
   assign stat.div_done   = div_done;

   assign sum_pair = SW'(g0_ff) + SW'(g1_ff);
   assign sum_diag = sum_pair + (interior ? SW'(g1_ff) + SW'(g2_ff) : SW'(0));
   assign sc_pair  = scale_sum(ts_ff, sum_pair);
   assign sc_diag  = scale_sum(ts_ff, sum_diag);
   assign smp32    = $signed(QW'(smp_ff));
   assign m_init   = Q_ONE + sc_pair;

   // rounded product of the registered magnitudes
   assign qm = sat_mag(pneg_ff, (pm_ff + MW'(32768)) >> 16);

   always_comb begin
      m_in = sat_sub(diag_ff, qm);
      if (m_in < Q_ONE) m_in = Q_ONE;
   end
   assign f_in   = sat_sub(smp32, qm);
   assign num_in = sat_sub(f_ff, qm);

   always_comb begin
      mul_a = lo_ff;
      mul_b = off_ff;
      unique case (cmd.mul_sel)
         MUL_LO_OFF: begin
            mul_a = lo_ff;
            mul_b = off_ff;
         end
         MUL_LO_F: begin
            mul_a = lo_ff;
            mul_b = f_ff;
         end
         MUL_OFF_X: begin
            mul_a = off_ff;
            mul_b = x_ff;
         end
         default: begin
            mul_a = lo_ff;
            mul_b = off_ff;
         end
      endcase
   end

   always_comb begin
      div_num = off_ff;
      unique case (cmd.div_src)
         DIV_OFF_M: div_num = off_ff;
         DIV_F_M:   div_num = f_ff;
         DIV_NUM_M: div_num = num_in;
         default:   div_num = off_ff;
      endcase
   end

   aosrts_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (m_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      smp_ra  = '0;
      cond_ra = '0;
      unique case (cmd.rd_sel)
         RD_ZERO: begin
            smp_ra  = '0;
            cond_ra = '0;
         end
         RD_ONE: begin
            smp_ra  = '0;
            cond_ra = AW'(1);
         end
         RD_FWD: begin
            smp_ra  = idx_p1;
            cond_ra = idx_p2;
         end
         RD_IDX: begin
            smp_ra  = idx_ff;
            cond_ra = idx_ff;
         end
      endcase
   end

   assign smp_we  = (cmd.store && room) || cmd.ld_x;
   assign smp_wa  = cmd.ld_x ? idx_ff : fill_ff[AW-1:0];
   assign smp_wd  = cmd.ld_x ? sat_pix(div_q) : req_pixel_value;
   assign cond_we = cmd.store && room;
   assign piv_we  = cmd.init_row || cmd.ld_piv;
   assign fwd_we  = cmd.init_row || cmd.ld_fwd;
   assign piv_wa  = cmd.init_row ? '0 : idx_p1;
   assign piv_wd  = cmd.init_row ? $unsigned(m_init) : $unsigned(m_in);
   assign fwd_wd  = cmd.init_row ? $unsigned(smp32) : $unsigned(f_in);

   aosrts_ram #(.WIDTH(PIX_W), .DEPTH(ROW_LEN)) u_sample_store (
      .clock (clock), .wr_en (smp_we), .wr_addr (smp_wa), .wr_data (smp_wd),
      .rd_addr (smp_ra), .rd_data (smp_q)
   );

   aosrts_ram #(.WIDTH(PIX_W), .DEPTH(ROW_LEN)) u_conductance_store (
      .clock (clock), .wr_en (cond_we), .wr_addr (fill_ff[AW-1:0]),
      .wr_data (req_diffusivity), .rd_addr (cond_ra), .rd_data (cond_q)
   );

   aosrts_ram #(.WIDTH(QW), .DEPTH(ROW_LEN)) u_pivot_store (
      .clock (clock), .wr_en (piv_we), .wr_addr (piv_wa), .wr_data (piv_wd),
      .rd_addr (idx_ff), .rd_data (piv_q)
   );

   aosrts_ram #(.WIDTH(QW), .DEPTH(ROW_LEN)) u_forward_store (
      .clock (clock), .wr_en (fwd_we), .wr_addr (piv_wa), .wr_data (fwd_wd),
      .rd_addr (idx_ff), .rd_data (fwd_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff   <= TS_RESET;
         fill_ff <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) ts_ff <= csr_wr_data;
         if (cmd.store) begin
            if (room) fill_ff <= fill_ff + CW'(1);
            else      ovf_ff  <= 1'b1;
         end else if (cmd.row_done) begin
            fill_ff <= '0;
            ovf_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         priority if (cmd.init_row || cmd.out_init) begin
            idx_ff <= '0;
         end else if (cmd.ld_fwd || cmd.out_next) begin
            idx_ff <= idx_p1;
         end else if (cmd.ld_x) begin
            idx_ff <= idx_ff - AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      pm_ff   <= MW'(mag(mul_a)) * MW'(mag(mul_b));
      pneg_ff <= mul_a[QW-1] ^ mul_b[QW-1];
      if (cmd.ld_head) begin
         g0_ff  <= cond_q;
         smp_ff <= smp_q;
      end
      if (cmd.ld_g1 || cmd.ld_back) g1_ff <= cond_q;
      if (cmd.init_row) begin
         m_ff <= m_init;
         f_ff <= smp32;
      end
      if (cmd.ld_off)  off_ff  <= -sc_pair;
      if (cmd.ld_next) begin
         g2_ff  <= cond_q;
         smp_ff <= smp_q;
      end
      if (cmd.ld_diag) diag_ff <= Q_ONE + sc_diag;
      if (cmd.ld_lo)   lo_ff   <= div_q;
      if (cmd.ld_piv)  m_ff    <= m_in;
      if (cmd.ld_fwd) begin
         f_ff  <= f_in;
         g0_ff <= g1_ff;
         g1_ff <= g2_ff;
      end
      if (cmd.ld_back) begin
         f_ff <= $signed(fwd_q);
         m_ff <= $signed(piv_q);
      end
      if (cmd.ld_x) begin
         x_ff <= div_q;
         if (cmd.shift_back) g0_ff <= g1_ff;
      end
      if (cmd.ld_rsp) begin
         rsp_value_ff <= smp_q;
         rsp_end_ff   <= stat.out_last;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_solved_value = rsp_value_ff;
   assign rsp_result_end   = rsp_end_ff;
   assign rsp_row_overflow = rsp_ovf_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(ROW_LEN)) else $error("fill count beyond store");
   a_pivot_floor: assert property (@(posedge clock) disable iff (reset)
      (cmd.ld_piv || cmd.init_row) |=> (m_ff >= Q_ONE)) else $error("pivot below one");
endmodule

FILE: src/aos_row_tridiagonal_solve.sv
// ----------------------------------------------------------------------------
// aos_row_tridiagonal_solve
// Implicit diffusion row solve: builds the tridiagonal system from the row
// conductances and solves it with forward elimination and back substitution.
//
//   channel   dir   transaction
//   req_ch    in    pixel_value, diffusivity, row_end
//   rsp_ch    out   solved_value, result_end, row_overflow
//   csr_*     in    time_step write
//
// samples are taken one per cycle until row_end; then the row is solved
// each row element costs two bit-serial divisions (forward and back pass) on the
// one shared divider, plus further sequencer steps
// results go out registered; no sample is taken until the row is out
// synchronous reset clears the sequencer, fill count and time_step (1.0)
// ----------------------------------------------------------------------------
module aos_row_tridiagonal_solve #(
   parameter int ROW_LEN = aosrts_pkg::ROW_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   aosrts_req_if.sink                    req_ch,
   aosrts_rsp_if.source                  rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [aosrts_pkg::PIX_W-1:0]  csr_wr_data
);
   import aosrts_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   aosrts_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_row_end (req_ch.row_end),
      .req_ready   (req_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   aosrts_dp #(.ROW_LEN(ROW_LEN)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_pixel_value  (req_ch.pixel_value),
      .req_diffusivity  (req_ch.diffusivity),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_solved_value (rsp_ch.solved_value),
      .rsp_result_end   (rsp_ch.result_end),
      .rsp_row_overflow (rsp_ch.row_overflow)
   );
endmodule

FILE: test/aos_row_tridiagonal_solve_tb.sv
// ----------------------------------------------------------------------------
// aos_row_tridiagonal_solve_tb
// Streams image rows with conductances into the row solver and checks each
// solved sample against a fixed-point Thomas solve kept in the bench, over
// several time steps, truncated rows, random gaps and output back-pressure.
// ----------------------------------------------------------------------------
module aos_row_tridiagonal_solve_tb;
   import aosrts_pkg::*;

   localparam int STORE_LEN = ROW_LEN_DEF;
   localparam int EXP_DEPTH = 2 * STORE_LEN;
   localparam int HOLD_LEN  = 1500;

   typedef struct {
      logic [PIX_W-1:0] solved_value;
      logic             result_end;
      logic             row_overflow;
   } solution_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic [PIX_W-1:0] csr_wr_data = '0;

   aosrts_req_if req_ch();
   aosrts_rsp_if rsp_ch();

   aos_row_tridiagonal_solve #(.ROW_LEN(STORE_LEN)) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // bench copy of the block state
   logic [PIX_W-1:0] step_q88 = TS_RESET;
   logic [PIX_W-1:0] row_samples [STORE_LEN];
   logic [PIX_W-1:0] row_cond [STORE_LEN];
   int               row_fill = 0;
   bit               row_truncated = 1'b0;
   solution_type     expect_buf [EXP_DEPTH];
   int               exp_wr = 0;
   int               exp_rd = 0;
   int               err_count = 0;
   bit               quiet_mode = 1'b0;
   bit               rsp_hold = 1'b0;
   event             hold_go;

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned mag(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint qmul(longint a, longint b);
      longint unsigned r;
      longint s;
      r = (mag(a) * mag(b) + 64'd32768) >> 16;
      s = longint'(r);
      return sat32(((a < 0) != (b < 0)) ? -s : s);
   endfunction

   function automatic longint qdiv(longint num, longint den);
      longint unsigned d, q;
      longint s;
      d = longint'(den);
      q = ((mag(num) << 16) + d / 2) / d;
      s = longint'(q);
      return sat32((num < 0) ? -s : s);
   endfunction

   function automatic longint step_scale(longint unsigned sum);
      return longint'((longint'(step_q88) * sum + 64'd128) >> 8);
   endfunction

   function automatic longint diag_term(int i, int n);
      longint unsigned s;
      s = row_cond[i];
      if (i > 0) s += row_cond[i-1];
      if (i + 1 < n) s += row_cond[i+1];
      if (i > 0 && i + 1 < n) s += row_cond[i];
      return sat32(64'sd65536 + step_scale(s));
   endfunction

   function automatic longint off_term(int i);
      return sat32(-step_scale(longint'(row_cond[i]) + longint'(row_cond[i+1])));
   endfunction

   function automatic longint pivot_floor(longint m);
      return (m < 64'sd65536) ? 64'sd65536 : m;
   endfunction

   // thomas solve of the stored row, queues expected solution samples
   function automatic void solve_row();
      longint piv [STORE_LEN];
      longint fwd [STORE_LEN];
      longint sol [STORE_LEN];
      longint lo, off, x, num;
      int n;
      solution_type s;
      n = row_fill;
      if (n == 1) begin
         sol[0] = row_samples[0];
      end else begin
         piv[0] = pivot_floor(diag_term(0, n));
         fwd[0] = row_samples[0];
         for (int i = 0; i + 1 < n; i++) begin
            off = off_term(i);
            lo = qdiv(off, piv[i]);
            piv[i+1] = pivot_floor(sat32(diag_term(i + 1, n) - qmul(lo, off)));
            fwd[i+1] = sat32(longint'(row_samples[i+1]) - qmul(lo, fwd[i]));
         end
         x = qdiv(fwd[n-1], piv[n-1]);
         sol[n-1] = x;
         for (int i = n - 2; i >= 0; i--) begin
            num = sat32(fwd[i] - qmul(off_term(i), x));
            x = qdiv(num, piv[i]);
            sol[i] = x;
         end
      end
      for (int i = 0; i < n; i++) begin
         s.solved_value = (sol[i] < 0) ? 16'd0 : (sol[i] > 65535 ? 16'hffff : sol[i][15:0]);
         s.result_end = (i + 1 == n);
         s.row_overflow = row_truncated;
         expect_buf[exp_wr % EXP_DEPTH] = s;
         exp_wr++;
      end
      row_fill = 0;
      row_truncated = 1'b0;
   endfunction

   function automatic void take_sample(logic [PIX_W-1:0] pix, logic [PIX_W-1:0] g,
                                       logic last);
      if (row_fill < STORE_LEN) begin
         row_samples[row_fill] = pix;
         row_cond[row_fill] = g;
         row_fill++;
      end else begin
         row_truncated = 1'b1;
      end
      if (last) solve_row();
   endfunction

   function automatic int gap_len();
      int r;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [PIX_W-1:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hffff;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // one input transaction, entered and left at a falling edge
   task automatic send_sample(logic [PIX_W-1:0] pix, logic [PIX_W-1:0] g, logic last);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.pixel_value <= pix;
      req_ch.diffusivity <= g;
      req_ch.row_end     <= last;
      req_ch.valid       <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      take_sample(pix, g, last);
      @(negedge clock);
   endtask

   task automatic send_row(int len, bit extreme);
      for (int i = 0; i < len; i++) begin
         if (extreme)
            send_sample(($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000, 16'hffff,
                        i == len - 1);
         else
            send_sample(rand_word(), rand_word(), i == len - 1);
      end
   endtask

   task automatic settle_and_set_step(logic [PIX_W-1:0] v);
      req_ch.valid <= 1'b0;
      while (exp_wr != exp_rd) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      step_q88 = v;
   endtask

   task automatic test_directed();
      send_sample(16'hffff, 16'hffff, 1'b1);
      send_sample(16'h0000, 16'h0000, 1'b1);
      send_sample(16'h1234, 16'h8000, 1'b1);
      send_row(2, 1'b1);
      send_row(3, 1'b1);
      send_sample(16'hffff, 16'h0000, 1'b0);
      send_sample(16'h0000, 16'h0000, 1'b0);
      send_sample(16'hffff, 16'h0000, 1'b1);
      send_row(4, 1'b0);
      settle_and_set_step(16'h0000);
      send_row(3, 1'b1);
      send_row(2, 1'b0);
      settle_and_set_step(16'hffff);
      send_row(3, 1'b1);
      send_row(5, 1'b0);
   endtask

   task automatic test_truncated_row();
      send_row(STORE_LEN, 1'b0);
      send_row(STORE_LEN + 2, 1'b0);
   endtask

   task automatic test_output_stall();
      send_row(6, 1'b0);
      -> hold_go;
      send_row(5, 1'b0);
      send_row(3, 1'b0);
   endtask

   task automatic test_random_rows(int items);
      int sent, len, r;
      sent = 0;
      while (sent < items) begin
         r = $urandom_range(0, 49);
         if (r == 0) len = $urandom_range(STORE_LEN + 1, STORE_LEN + 4);
         else if (r < 3) len = $urandom_range(20, STORE_LEN);
         else len = $urandom_range(1, 8);
         quiet_mode = ($urandom_range(0, 5) == 0);
         send_row(len, 1'b0);
         sent += len;
      end
      quiet_mode = 1'b0;
   endtask

   // long receiver hold-off, counted in its own process
   initial begin
      forever begin
         @(hold_go);
         rsp_hold = 1'b1;
         repeat (HOLD_LEN) @(negedge clock);
         rsp_hold = 1'b0;
      end
   end

   // result side: ready with random stalls and the forced hold-off
   int stall_left = 0;
   always @(negedge clock) begin
      if (rsp_hold) begin
         rsp_ch.ready <= 1'b0;
      end else if (quiet_mode || stall_left == 0) begin
         if (!quiet_mode && $urandom_range(0, 9) >= 7) begin
            stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end else begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (exp_wr == exp_rd) begin
            $display("%0t: unexpected transaction value=%h end=%b ovf=%b", $time,
                     rsp_ch.solved_value, rsp_ch.result_end, rsp_ch.row_overflow);
            err_count++;
         end else begin
            solution_type e;
            e = expect_buf[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (rsp_ch.solved_value !== e.solved_value) begin
               $display("%0t: solved_value expected %h actual %h", $time,
                        e.solved_value, rsp_ch.solved_value);
               err_count++;
            end
            if (rsp_ch.result_end !== e.result_end) begin
               $display("%0t: result_end expected %b actual %b", $time,
                        e.result_end, rsp_ch.result_end);
               err_count++;
            end
            if (rsp_ch.row_overflow !== e.row_overflow) begin
               $display("%0t: row_overflow expected %b actual %b", $time,
                        e.row_overflow, rsp_ch.row_overflow);
               err_count++;
            end
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.pixel_value = '0;
      req_ch.diffusivity = '0;
      req_ch.row_end = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_truncated_row();
      settle_and_set_step(TS_RESET);
      test_output_stall();
      test_random_rows(100);
      settle_and_set_step(16'($urandom_range(1, 65534)));
      test_random_rows(70);
      settle_and_set_step(16'h0001);
      test_random_rows(60);
      settle_and_set_step(16'h0800);
      test_random_rows(80);
      req_ch.valid <= 1'b0;
      while (exp_wr != exp_rd) @(negedge clock);
      repeat (200) @(negedge clock);
      if (err_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
